// ===== src/awqdq_pkg.sv =====
// ----------------------------------------------------------------------------
// awqdq_pkg
// types and lane arithmetic for the awq int4 weight dequantizer
// ----------------------------------------------------------------------------
package awqdq_pkg;

    localparam int LANES = 8;
    localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;

    typedef struct packed {
        logic [31:0] weight_word;
        logic [31:0] zero_word;
        logic [31:0] scale_0;
        logic [31:0] scale_1;
        logic [31:0] scale_2;
        logic [31:0] scale_3;
        logic [31:0] scale_4;
        logic [31:0] scale_5;
        logic [31:0] scale_6;
        logic [31:0] scale_7;
    } t_in;

    typedef struct packed {
        logic [31:0] value_0;
        logic [31:0] value_1;
        logic [31:0] value_2;
        logic [31:0] value_3;
        logic [31:0] value_4;
        logic [31:0] value_5;
        logic [31:0] value_6;
        logic [31:0] value_7;
        logic [31:0] lane_nibbles;
    } t_out;

    // bit offset of lane k's nibble in the packed words
    function automatic logic [4:0] lane_shift(input logic [2:0] k);
        logic [4:0] sh;
        case (k)
            3'd0: sh = 5'd0;
            3'd1: sh = 5'd16;
            3'd2: sh = 5'd4;
            3'd3: sh = 5'd20;
            3'd4: sh = 5'd8;
            3'd5: sh = 5'd24;
            3'd6: sh = 5'd12;
            default: sh = 5'd28;
        endcase
        return sh;
    endfunction

    function automatic logic [4:0] lead_one(input logic [27:0] p);
        logic [4:0] pos;
        pos = 5'd0;
        for (int i = 0; i < 28; i++) begin
            if (p[i]) pos = 5'(i);
        end
        return pos;
    endfunction

    // fp32 operand (sign sf, bits s[30:0]) times integer of sign si, magnitude m
    function automatic logic [31:0] fp_mul_int(input logic [31:0] s, input logic sf,
                                               input logic [3:0] m, input logic si);
        logic        sr;
        logic [7:0]  ex;
        logic [22:0] fr;
        logic [8:0]  e;
        logic [27:0] p;
        logic [4:0]  l;
        logic signed [10:0] eb;
        logic [27:0] pn;
        logic [23:0] m24;
        logic        up;
        logic [24:0] sum;
        logic signed [10:0] ef;
        logic [31:0] sub;
        logic [31:0] r;
        sr  = sf ^ si;
        ex  = s[30:23];
        fr  = s[22:0];
        e   = (ex == 8'd0) ? 9'd1 : {1'b0, ex};
        p   = {(ex != 8'd0), fr} * m;
        l   = lead_one(p);
        eb  = 11'($signed({6'd0, l})) + 11'($signed({2'd0, e})) - 11'sd23;
        pn  = p << (5'd27 - l);
        m24 = pn[27:4];
        up  = pn[3] & ((|pn[2:0]) | m24[0]);
        sum = {1'b0, m24} + {24'd0, up};
        ef  = sum[24] ? eb + 11'sd1 : eb;
        sub = {4'd0, p} << 5'(e - 9'd1);
        if (ex == 8'hFF && fr != 23'd0) begin
            r = {sf, 8'hFF, 1'b1, fr[21:0]};
        end else if (ex == 8'hFF) begin
            r = (m == 4'd0) ? QNAN_DEFAULT : {sr, 8'hFF, 23'd0};
        end else if (p == 28'd0) begin
            r = {sr, 31'd0};
        end else if (eb <= 11'sd0) begin
            r = {sr, 8'd0, sub[22:0]};
        end else if (ef >= 11'sd255) begin
            r = {sr, 8'hFF, 23'd0};
        end else begin
            r = {sr, ef[7:0], sum[24] ? sum[23:1] : sum[22:0]};
        end
        return r;
    endfunction

endpackage

// ===== src/awq_int4_weight_dequant_unit.sv =====
// ----------------------------------------------------------------------------
// awq_int4_weight_dequant_unit
// unpacks one awq int4 weight word and dequantizes its eight lanes to fp32
// ----------------------------------------------------------------------------
// One packed word is taken in each cycle (busy never rises). The start transfer
// loads the input register; the next edge moves the word through the eight lane
// multipliers into the result register, so the result shows for one cycle under
// o_valid right after that edge. The receiver cannot stall, so results must be
// taken on the cycle they appear. Output mode is sampled with each word: mode 0
// gives scale*(w-z) per lane, mode 1 gives -scale*z with the raw nibbles.
module awq_int4_weight_dequant_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               start,
    output logic               busy,
    input  awqdq_pkg::t_in     i_in,
    output logic               o_valid,
    output awqdq_pkg::t_out    o_out
);

    logic              r_mode;
    logic              r_vld;
    logic              r_in_mode;
    awqdq_pkg::t_in    r_in;
    logic              r_out_vld;
    awqdq_pkg::t_out   r_out;
    awqdq_pkg::t_out   n_out;
    logic [31:0]       scale [awqdq_pkg::LANES];
    logic [31:0]       value [awqdq_pkg::LANES];
    logic [31:0]       nib;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= 1'b0;
            r_vld     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_cfg_we) r_mode <= i_cfg_wdata;
            r_vld     <= start;
            r_out_vld <= r_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_in      <= i_in;
            r_in_mode <= r_mode;
        end
        if (r_vld) r_out <= n_out;
    end

    always_comb begin
        logic [3:0] w;
        logic [3:0] z;
        logic [4:0] d;
        scale[0] = r_in.scale_0;
        scale[1] = r_in.scale_1;
        scale[2] = r_in.scale_2;
        scale[3] = r_in.scale_3;
        scale[4] = r_in.scale_4;
        scale[5] = r_in.scale_5;
        scale[6] = r_in.scale_6;
        scale[7] = r_in.scale_7;
        nib = 32'd0;
        for (int k = 0; k < awqdq_pkg::LANES; k++) begin
            w = 4'(r_in.weight_word >> awqdq_pkg::lane_shift(3'(k)));
            z = 4'(r_in.zero_word >> awqdq_pkg::lane_shift(3'(k)));
            d = {1'b0, w} - {1'b0, z};
            if (r_in_mode) begin
                value[k] = awqdq_pkg::fp_mul_int(scale[k], ~scale[k][31], z, 1'b0);
                nib[4*k +: 4] = w;
            end else begin
                value[k] = awqdq_pkg::fp_mul_int(scale[k], scale[k][31],
                                                 d[4] ? 4'(-d) : d[3:0], d[4]);
            end
        end
        n_out.value_0      = value[0];
        n_out.value_1      = value[1];
        n_out.value_2      = value[2];
        n_out.value_3      = value[3];
        n_out.value_4      = value[4];
        n_out.value_5      = value[5];
        n_out.value_6      = value[6];
        n_out.value_7      = value[7];
        n_out.lane_nibbles = nib;
    end

    assign o_valid = r_out_vld;
    assign o_out   = r_out;

endmodule
